// File: rtl/roac_pkg.sv
package roac_pkg;

   // drive directions
   localparam logic [2:0] DIR_STOP  = 3'd0;
   localparam logic [2:0] DIR_FWD   = 3'd1;
   localparam logic [2:0] DIR_BACK  = 3'd2;
   localparam logic [2:0] DIR_LEFT  = 3'd3;
   localparam logic [2:0] DIR_RIGHT = 3'd4;

   // navigation phases
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_FWD    = 3'd1;
   localparam logic [2:0] PH_REV    = 3'd2;
   localparam logic [2:0] PH_CHK_L  = 3'd3;
   localparam logic [2:0] PH_CHK_R  = 3'd4;
   localparam logic [2:0] PH_TURN_L = 3'd5;
   localparam logic [2:0] PH_TURN_R = 3'd6;

   // item opcodes and command modes
   localparam logic       OP_STEP     = 1'b0;
   localparam logic       OP_COMMAND  = 1'b1;
   localparam logic [1:0] CMD_MANUAL  = 2'd0;
   localparam logic [1:0] CMD_AUTO    = 2'd1;
   localparam logic [7:0] ID_BROADCAST = 8'd0;

   // dwell times in ms
   localparam logic [15:0] REVERSE_DWELL_MS     = 16'd600;
   localparam logic [15:0] CHECK_LEFT_DWELL_MS  = 16'd400;
   localparam logic [15:0] CHECK_RIGHT_DWELL_MS = 16'd800;
   localparam logic [15:0] TURN_DWELL_MS        = 16'd500;

   localparam logic signed [10:0] STICK_DEAD_POS = 11'sd100;
   localparam logic signed [10:0] STICK_MAX_POS  = 11'sd511;
   localparam logic signed [10:0] STICK_DEAD_NEG = -11'sd100;
   localparam logic signed [10:0] STICK_MAX_NEG  = -11'sd511;
   localparam logic [9:0]         TRIGGER_DEAD   = 10'd100;

   // configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_CM    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_CM     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MANUAL_DUTY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_DUTY   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_DUTY   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_DUTY   = 3'd7;

   typedef struct packed {
      logic [7:0]  own_robot_id;
      logic [15:0] manual_timeout_ms;
      logic [8:0]  clear_cm;
      logic [8:0]  near_cm;
      logic [13:0] manual_duty;
      logic [13:0] fast_duty;
      logic [13:0] slow_duty;
      logic [13:0] turn_duty;
   } cfg_type;

   typedef struct packed {
      logic               opcode;
      logic [15:0]        elapsed_ms;
      logic [8:0]         distance_cm;
      logic [1:0]         cmd_mode;
      logic [7:0]         target_id;
      logic signed [10:0] stick_x;
      logic [9:0]         brake_level;
      logic [9:0]         throttle_level;
   } item_type;

   typedef struct packed {
      logic [2:0]  drive_dir;
      logic [13:0] drive_duty;
      logic        auto_mode;
      logic [2:0]  nav_state;
   } result_type;

endpackage

// File: rtl/roac_csr.sv
module roac_csr
   import roac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_ID:      cfg_in.own_robot_id      = csr_data[7:0];
            CSR_TIMEOUT:     cfg_in.manual_timeout_ms = csr_data[15:0];
            CSR_CLEAR_CM:    cfg_in.clear_cm          = csr_data[8:0];
            CSR_NEAR_CM:     cfg_in.near_cm           = csr_data[8:0];
            CSR_MANUAL_DUTY: cfg_in.manual_duty       = csr_data[13:0];
            CSR_FAST_DUTY:   cfg_in.fast_duty         = csr_data[13:0];
            CSR_SLOW_DUTY:   cfg_in.slow_duty         = csr_data[13:0];
            CSR_TURN_DUTY:   cfg_in.turn_duty         = csr_data[13:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_robot_id      <= 8'd2;
         cfg_ff.manual_timeout_ms <= 16'd10000;
         cfg_ff.clear_cm          <= 9'd15;
         cfg_ff.near_cm           <= 9'd4;
         cfg_ff.manual_duty       <= 14'd4500;
         cfg_ff.fast_duty         <= 14'd2500;
         cfg_ff.slow_duty         <= 14'd1800;
         cfg_ff.turn_duty         <= 14'd2200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/roac_step.sv
module roac_step
   import roac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic        mode_ff, mode_in;
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] pt_ff, pt_in;
   logic [15:0] sc_ff, sc_in;
   logic [2:0]  dir_ff, dir_in;
   logic [13:0] duty_ff, duty_in;

   logic [16:0] pt_sum;
   logic [16:0] sc_sum;
   logic [15:0] pt_sat;
   logic [15:0] sc_sat;
   logic [8:0]  dist_cm;
   logic        is_clear;
   logic        is_near;
   logic        id_ok;

   assign pt_sum   = {1'b0, pt_ff} + {1'b0, item.elapsed_ms};
   assign sc_sum   = {1'b0, sc_ff} + {1'b0, item.elapsed_ms};
   assign pt_sat   = pt_sum[16] ? 16'hFFFF : pt_sum[15:0];
   assign sc_sat   = sc_sum[16] ? 16'hFFFF : sc_sum[15:0];
   assign dist_cm  = item.distance_cm;
   assign is_clear = dist_cm > cfg.clear_cm;
   assign is_near  = dist_cm <= cfg.near_cm;
   assign id_ok    = (item.target_id == ID_BROADCAST) || (item.target_id == cfg.own_robot_id);

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      pt_in    = pt_sat;
      sc_in    = sc_sat;
      dir_in   = dir_ff;
      duty_in  = duty_ff;

      if (item.opcode == OP_COMMAND) begin
         sc_in = 16'd0;
         unique case (item.cmd_mode)
            CMD_MANUAL: mode_in = 1'b0;
            CMD_AUTO: begin
               mode_in  = 1'b1;
               phase_in = PH_FWD;
            end
            default: mode_in = mode_ff;
         endcase
         // new drive only for a manual command addressed to this robot
         if (item.cmd_mode == CMD_MANUAL && id_ok) begin
            duty_in = cfg.manual_duty;
            if (item.stick_x > STICK_DEAD_POS && item.stick_x <= STICK_MAX_POS) begin
               dir_in = DIR_RIGHT;
            end else if (item.stick_x < STICK_DEAD_NEG && item.stick_x >= STICK_MAX_NEG) begin
               dir_in = DIR_LEFT;
            end else if (item.brake_level > TRIGGER_DEAD) begin
               dir_in = DIR_BACK;
            end else if (item.throttle_level > TRIGGER_DEAD) begin
               dir_in = DIR_FWD;
            end else begin
               dir_in  = DIR_STOP;
               duty_in = 14'd0;
            end
         end
      end else if (!mode_ff) begin
         // idle timeout: go autonomous, drive held
         if (sc_sat >= cfg.manual_timeout_ms) begin
            mode_in  = 1'b1;
            phase_in = PH_IDLE;
            pt_in    = 16'd0;
         end
      end else begin
         unique case (phase_ff) inside
            PH_IDLE: begin
               dir_in  = DIR_STOP;
               duty_in = 14'd0;
               if (is_clear) begin
                  phase_in = PH_FWD;
                  pt_in    = 16'd0;
               end else if (dist_cm != 9'd0 && is_near) begin
                  phase_in = PH_REV;
                  pt_in    = 16'd0;
               end
            end
            PH_FWD: begin
               if (dist_cm == 9'd0 || is_near) begin
                  dir_in   = DIR_STOP;
                  duty_in  = 14'd0;
                  phase_in = PH_REV;
                  pt_in    = 16'd0;
               end else begin
                  dir_in  = DIR_FWD;
                  duty_in = is_clear ? cfg.fast_duty : cfg.slow_duty;
               end
            end
            PH_REV: begin
               dir_in  = DIR_BACK;
               duty_in = cfg.slow_duty;
               if (pt_sat >= REVERSE_DWELL_MS) begin
                  dir_in   = DIR_STOP;
                  duty_in  = 14'd0;
                  phase_in = PH_CHK_L;
                  pt_in    = 16'd0;
               end
            end
            PH_CHK_L: begin
               dir_in  = DIR_LEFT;
               duty_in = cfg.slow_duty;
               if (pt_sat >= CHECK_LEFT_DWELL_MS) begin
                  dir_in   = DIR_STOP;
                  duty_in  = 14'd0;
                  phase_in = is_clear ? PH_TURN_L : PH_CHK_R;
                  pt_in    = 16'd0;
               end
            end
            PH_CHK_R: begin
               dir_in  = DIR_RIGHT;
               duty_in = cfg.slow_duty;
               if (pt_sat >= CHECK_RIGHT_DWELL_MS) begin
                  dir_in   = DIR_STOP;
                  duty_in  = 14'd0;
                  phase_in = is_clear ? PH_TURN_R : PH_REV;
                  pt_in    = 16'd0;
               end
            end
            PH_TURN_L, PH_TURN_R: begin
               dir_in  = (phase_ff == PH_TURN_L) ? DIR_LEFT : DIR_RIGHT;
               duty_in = cfg.turn_duty;
               if (pt_sat >= TURN_DWELL_MS) begin
                  dir_in   = DIR_STOP;
                  duty_in  = 14'd0;
                  phase_in = PH_FWD;
                  pt_in    = 16'd0;
               end
            end
            default: begin
               // unused phase code: drop back to idle
               dir_in   = DIR_STOP;
               duty_in  = 14'd0;
               phase_in = PH_IDLE;
               pt_in    = 16'd0;
            end
         endcase
      end
   end

   assign result.drive_dir  = dir_in;
   assign result.drive_duty = duty_in;
   assign result.auto_mode  = mode_in;
   assign result.nav_state  = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         phase_ff <= PH_IDLE;
         pt_ff    <= 16'd0;
         sc_ff    <= 16'd0;
         dir_ff   <= DIR_STOP;
         duty_ff  <= 14'd0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         pt_ff    <= pt_in;
         sc_ff    <= sc_in;
         dir_ff   <= dir_in;
         duty_ff  <= duty_in;
      end
   end

endmodule

// File: rtl/robot_obstacle_avoid_controller.sv
// Channel   Ports                                    Moves
// req       req_valid / req_ready, req_* fields      one step or command item
// rsp       rsp_valid / rsp_ready, rsp_* fields      one drive result per item
// csr       csr_valid / csr_ready, csr_index/data    one register write
//
// An item is registered on acceptance and its result is registered when the
// item advances, and one item is taken every cycle while the result is not stalled.
// The controller state (mode, phase, timers, held drive) updates as the item
// moves into the result register, so the following item sees it at once.
// A stalled result holds the input register; csr_ready is always high.
// Reset (synchronous) restores the register defaults and manual mode.
module robot_obstacle_avoid_controller
   import roac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [15:0]           req_elapsed_ms,
   input  logic [8:0]            req_distance_cm,
   input  logic [1:0]            req_cmd_mode,
   input  logic [7:0]            req_target_id,
   input  logic signed [10:0]    req_stick_x,
   input  logic [9:0]            req_brake_level,
   input  logic [9:0]            req_throttle_level,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_drive_dir,
   output logic [13:0]           rsp_drive_duty,
   output logic                  rsp_auto_mode,
   output logic [2:0]            rsp_nav_state,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type rsp_ff;
   result_type step_result;
   logic       rsp_valid_ff;
   logic       advance;

   roac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   roac_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.opcode         <= req_opcode;
         item_ff.elapsed_ms     <= req_elapsed_ms;
         item_ff.distance_cm    <= req_distance_cm;
         item_ff.cmd_mode       <= req_cmd_mode;
         item_ff.target_id      <= req_target_id;
         item_ff.stick_x        <= req_stick_x;
         item_ff.brake_level    <= req_brake_level;
         item_ff.throttle_level <= req_throttle_level;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive_dir  = rsp_ff.drive_dir;
   assign rsp_drive_duty = rsp_ff.drive_duty;
   assign rsp_auto_mode  = rsp_ff.auto_mode;
   assign rsp_nav_state  = rsp_ff.nav_state;

endmodule

// File: tb/sv/tb_robot_obstacle_avoid_controller.sv
module tb_robot_obstacle_avoid_controller;
   import roac_pkg::*;

   // command modes the controller treats as a failed parse
   localparam logic [1:0] CMD_FAILED  = 2'd2;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   localparam cfg_type CFG_DEFAULT = '{
      own_robot_id: 8'd2, manual_timeout_ms: 16'd10000, clear_cm: 9'd15, near_cm: 9'd4,
      manual_duty: 14'd4500, fast_duty: 14'd2500, slow_duty: 14'd1800, turn_duty: 14'd2200};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_opcode;
   logic [15:0]           req_elapsed_ms;
   logic [8:0]            req_distance_cm;
   logic [1:0]            req_cmd_mode;
   logic [7:0]            req_target_id;
   logic signed [10:0]    req_stick_x;
   logic [9:0]            req_brake_level;
   logic [9:0]            req_throttle_level;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [2:0]            rsp_drive_dir;
   logic [13:0]           rsp_drive_duty;
   logic                  rsp_auto_mode;
   logic [2:0]            rsp_nav_state;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predicted controller state
   cfg_type     reg_cfg;
   logic        auto_on;
   logic [2:0]  phase;
   logic [15:0] phase_ms;
   logic [15:0] idle_ms;
   logic [2:0]  hold_dir;
   logic [13:0] hold_duty;

   result_type  drive_expect_q[$];
   bit          steady_flow;
   bit [7:0]    phases_seen;
   int unsigned n_items;
   int unsigned n_results;
   int unsigned n_errors;
   int unsigned n_settings;

   robot_obstacle_avoid_controller u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_elapsed_ms     (req_elapsed_ms),
      .req_distance_cm    (req_distance_cm),
      .req_cmd_mode       (req_cmd_mode),
      .req_target_id      (req_target_id),
      .req_stick_x        (req_stick_x),
      .req_brake_level    (req_brake_level),
      .req_throttle_level (req_throttle_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_dir      (rsp_drive_dir),
      .rsp_drive_duty     (rsp_drive_duty),
      .rsp_auto_mode      (rsp_auto_mode),
      .rsp_nav_state      (rsp_nav_state),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [15:0] sat16(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   function automatic void set_drive(logic [2:0] dir, logic [13:0] duty);
      hold_dir  = dir;
      hold_duty = (dir == DIR_STOP) ? 14'd0 : duty;
   endfunction

   function automatic void go_phase(logic [2:0] ph);
      set_drive(DIR_STOP, 14'd0);
      phase    = ph;
      phase_ms = 16'd0;
   endfunction

   function automatic void step_navigation(logic [8:0] d);
      logic [15:0] t;
      t = phase_ms;
      case (phase)
         PH_IDLE: begin
            set_drive(DIR_STOP, 14'd0);
            if (d > reg_cfg.clear_cm) go_phase(PH_FWD);
            else if (d != 9'd0 && d <= reg_cfg.near_cm) go_phase(PH_REV);
         end
         PH_FWD: begin
            if (d == 9'd0 || d <= reg_cfg.near_cm) go_phase(PH_REV);
            else if (d <= reg_cfg.clear_cm) set_drive(DIR_FWD, reg_cfg.slow_duty);
            else set_drive(DIR_FWD, reg_cfg.fast_duty);
         end
         PH_REV: begin
            set_drive(DIR_BACK, reg_cfg.slow_duty);
            if (t >= REVERSE_DWELL_MS) go_phase(PH_CHK_L);
         end
         PH_CHK_L: begin
            set_drive(DIR_LEFT, reg_cfg.slow_duty);
            if (t >= CHECK_LEFT_DWELL_MS)
               go_phase(d > reg_cfg.clear_cm ? PH_TURN_L : PH_CHK_R);
         end
         PH_CHK_R: begin
            set_drive(DIR_RIGHT, reg_cfg.slow_duty);
            if (t >= CHECK_RIGHT_DWELL_MS)
               go_phase(d > reg_cfg.clear_cm ? PH_TURN_R : PH_REV);
         end
         PH_TURN_L: begin
            set_drive(DIR_LEFT, reg_cfg.turn_duty);
            if (t >= TURN_DWELL_MS) go_phase(PH_FWD);
         end
         PH_TURN_R: begin
            set_drive(DIR_RIGHT, reg_cfg.turn_duty);
            if (t >= TURN_DWELL_MS) go_phase(PH_FWD);
         end
         default: go_phase(PH_IDLE);
      endcase
   endfunction

   function automatic void take_command(item_type it);
      logic signed [10:0] sx;
      sx = it.stick_x;
      if (it.cmd_mode == CMD_MANUAL) begin
         auto_on = 1'b0;
      end else if (it.cmd_mode == CMD_AUTO) begin
         auto_on = 1'b1;
         phase   = PH_FWD;
      end else begin
         return;
      end
      // the mode sticks even when the item is meant for another robot
      if (it.target_id != ID_BROADCAST && it.target_id != reg_cfg.own_robot_id) return;
      if (auto_on) return;
      if (sx > STICK_DEAD_POS && sx <= STICK_MAX_POS) set_drive(DIR_RIGHT, reg_cfg.manual_duty);
      else if (sx < STICK_DEAD_NEG && sx >= STICK_MAX_NEG)
         set_drive(DIR_LEFT, reg_cfg.manual_duty);
      else if (it.brake_level > TRIGGER_DEAD) set_drive(DIR_BACK, reg_cfg.manual_duty);
      else if (it.throttle_level > TRIGGER_DEAD) set_drive(DIR_FWD, reg_cfg.manual_duty);
      else set_drive(DIR_STOP, 14'd0);
   endfunction

   function automatic result_type predict_drive(item_type it);
      result_type r;
      phase_ms = sat16(phase_ms, it.elapsed_ms);
      idle_ms  = sat16(idle_ms, it.elapsed_ms);
      if (it.opcode == OP_COMMAND) begin
         idle_ms = 16'd0;
         take_command(it);
      end else if (!auto_on) begin
         if (idle_ms >= reg_cfg.manual_timeout_ms) begin
            auto_on  = 1'b1;
            phase    = PH_IDLE;
            phase_ms = 16'd0;
         end
      end else begin
         step_navigation(it.distance_cm);
      end
      r.drive_dir  = hold_dir;
      r.drive_duty = hold_duty;
      r.auto_mode  = auto_on;
      r.nav_state  = phase;
      return r;
   endfunction

   function automatic item_type make_step(logic [15:0] el, logic [8:0] dist_cm);
      item_type it;
      it.opcode         = OP_STEP;
      it.elapsed_ms     = el;
      it.distance_cm    = dist_cm;
      // command fields are ignored on a step: fill them with noise
      it.cmd_mode       = 2'($urandom_range(3));
      it.target_id      = 8'($urandom_range(255));
      it.stick_x        = 11'($urandom_range(2047));
      it.brake_level    = 10'($urandom_range(1023));
      it.throttle_level = 10'($urandom_range(1023));
      return it;
   endfunction

   function automatic item_type make_cmd(logic [1:0] mode, logic [7:0] id, int sx, int brake,
                                         int thr, logic [15:0] el);
      item_type it;
      it.opcode         = OP_COMMAND;
      it.elapsed_ms     = el;
      it.distance_cm    = 9'($urandom_range(511));
      it.cmd_mode       = mode;
      it.target_id      = id;
      it.stick_x        = sx[10:0];
      it.brake_level    = brake[9:0];
      it.throttle_level = thr[9:0];
      return it;
   endfunction

   function automatic logic [15:0] pick_elapsed();
      int r;
      r = $urandom_range(99);
      if (r < 80) return 16'($urandom_range(300));
      if (r < 95) return 16'($urandom_range(2000));
      return 16'($urandom_range(65535));
   endfunction

   function automatic item_type random_item();
      int r;
      int sx;
      int d;
      logic [1:0] mode;
      logic [7:0] id;
      r = $urandom_range(99);
      if (r < (auto_on ? 12 : 35)) begin
         r = $urandom_range(99);
         mode = (r < 45) ? CMD_MANUAL : (r < 85) ? CMD_AUTO :
                ($urandom_range(1) ? CMD_FAILED : CMD_UNKNOWN);
         r = $urandom_range(99);
         id = (r < 40) ? ID_BROADCAST : (r < 80) ? reg_cfg.own_robot_id
                                                 : 8'($urandom_range(255));
         case ($urandom_range(4))
            0: sx = $urandom_range(101, 511);
            1: sx = -int'($urandom_range(101, 511));
            2: sx = int'($urandom_range(200)) - 100;
            3: sx = $urandom_range(1) ? int'($urandom_range(512, 1023))
                                      : -int'($urandom_range(512, 1024));
            default: sx = int'($urandom_range(2047)) - 1024;
         endcase
         return make_cmd(mode, id, sx,
                         $urandom_range(1) ? $urandom_range(100) : $urandom_range(1023),
                         $urandom_range(1) ? $urandom_range(100) : $urandom_range(1023),
                         pick_elapsed());
      end
      // keep most distances near the thresholds so every branch gets hit
      case ($urandom_range(9))
         0:       d = 0;
         1, 2:    d = int'(reg_cfg.near_cm) + int'($urandom_range(4)) - 2;
         3, 4, 5: d = int'(reg_cfg.clear_cm) + int'($urandom_range(6)) - 3;
         default: d = $urandom_range(511);
      endcase
      if (d < 0) d = 0;
      if (d > 511) d = 511;
      return make_step(pick_elapsed(), d[8:0]);
   endfunction

   function automatic cfg_type rand_settings();
      cfg_type c;
      c.own_robot_id      = 8'($urandom_range(1, 255));
      c.manual_timeout_ms = ($urandom_range(99) < 70) ? 16'($urandom_range(1, 3000))
                                                      : 16'($urandom_range(1, 65535));
      c.clear_cm          = ($urandom_range(99) < 75) ? 9'($urandom_range(60))
                                                      : 9'($urandom_range(511));
      c.near_cm           = ($urandom_range(99) < 75) ? 9'($urandom_range(c.clear_cm))
                                                      : 9'($urandom_range(511));
      c.manual_duty       = 14'($urandom_range(16383));
      c.fast_duty         = 14'($urandom_range(16383));
      c.slow_duty         = 14'($urandom_range(16383));
      c.turn_duty         = 14'($urandom_range(16383));
      return c;
   endfunction

   function automatic int unsigned idle_cycles();
      int unsigned n;
      n = 0;
      if (!steady_flow)
         while ($urandom_range(99) < 27 && n < 20) n++;
      return n;
   endfunction

   task automatic send_item(input item_type it);
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= it.opcode;
      req_elapsed_ms     <= it.elapsed_ms;
      req_distance_cm    <= it.distance_cm;
      req_cmd_mode       <= it.cmd_mode;
      req_target_id      <= it.target_id;
      req_stick_x        <= it.stick_x;
      req_brake_level    <= it.brake_level;
      req_throttle_level <= it.throttle_level;
      do @(posedge clock); while (req_ready !== 1'b1);
      drive_expect_q.push_back(predict_drive(it));
      n_items++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_OWN_ID:      reg_cfg.own_robot_id      = data[7:0];
         CSR_TIMEOUT:     reg_cfg.manual_timeout_ms = data;
         CSR_CLEAR_CM:    reg_cfg.clear_cm          = data[8:0];
         CSR_NEAR_CM:     reg_cfg.near_cm           = data[8:0];
         CSR_MANUAL_DUTY: reg_cfg.manual_duty       = data[13:0];
         CSR_FAST_DUTY:   reg_cfg.fast_duty         = data[13:0];
         CSR_SLOW_DUTY:   reg_cfg.slow_duty         = data[13:0];
         CSR_TURN_DUTY:   reg_cfg.turn_duty         = data[13:0];
         default: ;
      endcase
   endtask

   task automatic run_phase(input cfg_type c, input bit steady);
      drain_results();
      write_reg(CSR_OWN_ID,      16'(c.own_robot_id));
      write_reg(CSR_TIMEOUT,     c.manual_timeout_ms);
      write_reg(CSR_CLEAR_CM,    16'(c.clear_cm));
      write_reg(CSR_NEAR_CM,     16'(c.near_cm));
      write_reg(CSR_MANUAL_DUTY, 16'(c.manual_duty));
      write_reg(CSR_FAST_DUTY,   16'(c.fast_duty));
      write_reg(CSR_SLOW_DUTY,   16'(c.slow_duty));
      write_reg(CSR_TURN_DUTY,   16'(c.turn_duty));
      csr_valid <= 1'b0;
      n_settings++;
      steady_flow = steady;
      repeat (150) send_item(random_item());
      steady_flow = 1'b0;
   endtask

   // stick, brake and throttle priority, the dead zones, the id filter and failed modes
   task automatic test_manual_drive();
      send_item(make_cmd(CMD_MANUAL, ID_BROADCAST, 200, 0, 0, 16'd10));
      send_item(make_cmd(CMD_MANUAL, 8'd2, -200, 0, 0, 16'd0));
      send_item(make_cmd(CMD_MANUAL, 8'd2, 511, 1023, 1023, 16'd0));
      send_item(make_cmd(CMD_MANUAL, 8'd2, -511, 0, 0, 16'd0));
      send_item(make_cmd(CMD_MANUAL, 8'd2, 512, 101, 0, 16'd0));
      send_item(make_cmd(CMD_MANUAL, 8'd2, -1024, 100, 1023, 16'd0));
      send_item(make_cmd(CMD_MANUAL, 8'd2, 1023, 0, 0, 16'd0));
      send_item(make_cmd(CMD_MANUAL, ID_BROADCAST, 100, 0, 101, 16'd0));
      send_item(make_cmd(CMD_MANUAL, 8'd255, 200, 0, 0, 16'd0));
      send_item(make_cmd(CMD_FAILED, 8'd2, -300, 0, 0, 16'd0));
      send_item(make_cmd(CMD_UNKNOWN, 8'd2, 0, 500, 0, 16'd0));
   endtask

   // walk the avoidance machine through its dwells, then the idle timeout
   task automatic test_auto_navigation();
      send_item(make_cmd(CMD_AUTO, ID_BROADCAST, 0, 0, 0, 16'd0));
      send_item(make_step(16'd0, 9'd100));
      send_item(make_step(16'd0, 9'd10));
      send_item(make_step(16'd0, 9'd3));
      send_item(make_step(16'd600, 9'd3));
      send_item(make_step(16'd400, 9'd100));
      send_item(make_step(16'd500, 9'd100));
      send_item(make_step(16'd0, 9'd0));
      send_item(make_step(16'hFFFF, 9'd511));
      send_item(make_step(16'd400, 9'd5));
      send_item(make_step(16'd800, 9'd100));
      send_item(make_step(16'd500, 9'd50));
      send_item(make_cmd(CMD_MANUAL, ID_BROADCAST, 0, 0, 0, 16'd0));
      send_item(make_step(16'hFFFF, 9'd20));
      send_item(make_step(16'd0, 9'd0));
      send_item(make_step(16'd0, 9'd3));
   endtask

   task automatic test_register_sweep();
      cfg_type lo_cfg;
      cfg_type hi_cfg;
      lo_cfg = '{8'd1, 16'd1, 9'd0, 9'd0, 14'd0, 14'd0, 14'd0, 14'd0};
      hi_cfg = '{8'd255, 16'hFFFF, 9'd511, 9'd511, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF};
      run_phase(lo_cfg, 1'b0);
      run_phase(hi_cfg, 1'b0);
      for (int k = 0; k < 4; k++) run_phase(rand_settings(), k == 2);
   endtask

   // hold the result port back at random, except during a steady stretch
   always @(posedge clock) rsp_ready <= steady_flow || ($urandom_range(99) >= 27);

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         n_results++;
         phases_seen[rsp_nav_state] = 1'b1;
         if (drive_expect_q.size() == 0) begin
            $error("result item with no item outstanding");
            n_errors++;
         end else begin
            want = drive_expect_q.pop_front();
            if (rsp_drive_dir !== want.drive_dir) begin
               $error("drive_dir: expected %0d, got %0d", want.drive_dir, rsp_drive_dir);
               n_errors++;
            end
            if (rsp_drive_duty !== want.drive_duty) begin
               $error("drive_duty: expected %0d, got %0d", want.drive_duty, rsp_drive_duty);
               n_errors++;
            end
            if (rsp_auto_mode !== want.auto_mode) begin
               $error("auto_mode: expected %0d, got %0d", want.auto_mode, rsp_auto_mode);
               n_errors++;
            end
            if (rsp_nav_state !== want.nav_state) begin
               $error("nav_state: expected %0d, got %0d", want.nav_state, rsp_nav_state);
               n_errors++;
            end
         end
      end
   end

   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      rsp_ready          = 1'b0;
      req_valid          = 1'b0;
      req_opcode         = OP_STEP;
      req_elapsed_ms     = '0;
      req_distance_cm    = '0;
      req_cmd_mode       = CMD_MANUAL;
      req_target_id      = ID_BROADCAST;
      req_stick_x        = '0;
      req_brake_level    = '0;
      req_throttle_level = '0;
      csr_valid          = 1'b0;
      csr_index          = CSR_OWN_ID;
      csr_data           = '0;
      reg_cfg            = CFG_DEFAULT;
      auto_on            = 1'b0;
      phase              = PH_IDLE;
      phase_ms           = '0;
      idle_ms            = '0;
      hold_dir           = DIR_STOP;
      hold_duty          = '0;
      steady_flow        = 1'b0;
      phases_seen        = '0;
      n_items            = 0;
      n_results          = 0;
      n_errors           = 0;
      n_settings         = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_manual_drive();
      test_auto_navigation();
      test_register_sweep();
      drain_results();
      repeat (10) @(posedge clock);

      $display("Ran %0d step and command items over %0d register settings, %0d results checked.",
               n_items, n_settings + 1, n_results);
      $display("Navigation phases reported (bit per phase): %b, mismatches: %0d",
               phases_seen, n_errors);
      if (n_errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: sim.f
rtl/roac_pkg.sv
rtl/roac_csr.sv
rtl/roac_step.sv
rtl/robot_obstacle_avoid_controller.sv
tb/sv/tb_robot_obstacle_avoid_controller.sv
